// File: design/text_console_writer_top_defines.svh
// Assertion macros for the text console writer.
// Used by modules that check their own sequencing; needs clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// same-cycle implication
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tcw_pkg.sv
// Shared types and constants of the text console writer.
// No dependencies.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int KIND_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int ROW_IN_W = 5;
  localparam int COL_IN_W = 7;
  localparam int LINES_W  = 5;
  localparam int CELL_W   = 16;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE     = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE       = 8'h20;
  localparam logic [CHAR_W-1:0] TEXT_COLOR_RESET = 8'h02;

  typedef enum logic [1:0] {
    KIND_PUT,
    KIND_READ,
    KIND_SCROLL,
    KIND_CLEAR
  } kind_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT_WR,
    ST_ADVANCE,
    ST_SCR_OFF,
    ST_SCR_LIM,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_BLANK,
    ST_RD_REQ,
    ST_RD_DATA,
    ST_DONE
  } state_e;

endpackage

// File: design/tcw_screen_mem.sv
// Screen cell memory: one write port, one read port with registered data.
// Depends on tcw_pkg.
module tcw_screen_mem #(
  parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [tcw_pkg::CELL_W-1:0]  wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [tcw_pkg::CELL_W-1:0]  rdata_o
);

  logic [tcw_pkg::CELL_W-1:0] mem_q [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/tcw_addr_unit.sv
// Shared address unit: row * COLUMNS + column.
// Depends on nothing but its parameters.
module tcw_addr_unit #(
  parameter int COLUMNS = 80,
  parameter int MA_W    = 5,
  parameter int MB_W    = 7,
  parameter int AW      = 11
) (
  input  logic [MA_W-1:0] row_i,
  input  logic [MB_W-1:0] col_i,
  output logic [AW-1:0]   addr_o
);

  localparam int PW = MA_W + MB_W + 1;

  logic [PW-1:0] full;

  assign full   = PW'(row_i) * PW'(COLUMNS) + PW'(col_i);
  assign addr_o = full[AW-1:0];

endmodule

// File: design/tcw_seq.sv
// Sequencer of the text console writer: cursor, walks over the screen, result.
// Depends on tcw_pkg, tcw_addr_unit and text_console_writer_top_defines.svh.
`include "text_console_writer_top_defines.svh"

module tcw_seq #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  parameter int AW      = $clog2(ROWS * COLUMNS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [tcw_pkg::KIND_W-1:0]    kind_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::ROW_IN_W-1:0]  cell_row_i,
  input  logic [tcw_pkg::COL_IN_W-1:0]  cell_column_i,
  input  logic [tcw_pkg::LINES_W-1:0]   line_count_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    color_i,
  input  logic [tcw_pkg::CELL_W-1:0]    mem_rdata_i,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]    mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o,
  output logic                          done_o,
  output logic [tcw_pkg::ROW_IN_W-1:0]  cursor_row_o,
  output logic [tcw_pkg::COL_IN_W-1:0]  cursor_column_o,
  output logic [tcw_pkg::CELL_W-1:0]    cell_value_o
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int MA_W  = ($clog2(ROWS + 1) > tcw_pkg::LINES_W) ?
                         $clog2(ROWS + 1) : tcw_pkg::LINES_W;
  localparam int MB_W  = ($clog2(COLUMNS + 1) > tcw_pkg::COL_IN_W) ?
                         $clog2(COLUMNS + 1) : tcw_pkg::COL_IN_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

  tcw_pkg::state_e state_q, state_d;
  tcw_pkg::kind_e  kind_q, kind_d;
  logic [tcw_pkg::CHAR_W-1:0]  ch_q, ch_d;
  logic [tcw_pkg::LINES_W-1:0] n_q, n_d;
  logic [RW-1:0]               y_q, y_d;
  logic [CW-1:0]               x_q, x_d;
  logic [AW-1:0]               addr_q, addr_d;
  logic [AW-1:0]               off_q, off_d;
  logic [AW-1:0]               lim_q, lim_d;
  logic [tcw_pkg::CELL_W-1:0]  value_q, value_d;

  logic [MA_W-1:0] op_a;
  logic [MB_W-1:0] op_b;
  logic [AW-1:0]   unit_sum;
  logic [AW-1:0]   addr_next;
  logic [MA_W-1:0] rows_left;
  logic            in_range;
  logic            we;
  logic [tcw_pkg::CELL_W-1:0] wdata;

  tcw_addr_unit #(
    .COLUMNS (COLUMNS),
    .MA_W    (MA_W),
    .MB_W    (MB_W),
    .AW      (AW)
  ) u_addr (
    .row_i  (op_a),
    .col_i  (op_b),
    .addr_o (unit_sum)
  );

  assign addr_next = addr_q + AW'(1);
  assign rows_left = MA_W'(ROWS) - MA_W'(n_q);
  assign in_range  = (MA_W'(cell_row_i) < MA_W'(ROWS)) &&
                     (MB_W'(cell_column_i) < MB_W'(COLUMNS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_INIT;
      kind_q  <= tcw_pkg::KIND_PUT;
      y_q     <= '0;
      x_q     <= '0;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      y_q     <= y_d;
      x_q     <= x_d;
      addr_q  <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    n_q     <= n_d;
    off_q   <= off_d;
    lim_q   <= lim_d;
    value_q <= value_d;
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    ch_d    = ch_q;
    n_d     = n_q;
    y_d     = y_q;
    x_d     = x_q;
    addr_d  = addr_q;
    off_d   = off_q;
    lim_d   = lim_q;
    value_d = value_q;
    op_a    = '0;
    op_b    = '0;
    we      = 1'b0;
    wdata   = {color_i, tcw_pkg::SPACE_CODE};
    unique case (state_q)
      tcw_pkg::ST_INIT: begin
        we    = 1'b1;
        wdata = {tcw_pkg::TEXT_COLOR_RESET, tcw_pkg::SPACE_CODE};
        if (addr_q == LAST_ADDR) begin
          addr_d  = '0;
          state_d = tcw_pkg::ST_IDLE;
        end else begin
          addr_d = addr_next;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (start_i) begin
          kind_d  = tcw_pkg::kind_e'(kind_i);
          ch_d    = char_code_i;
          n_d     = line_count_i;
          value_d = '0;
          addr_d  = '0;
          unique case (tcw_pkg::kind_e'(kind_i))
            tcw_pkg::KIND_PUT: begin
              if (char_code_i == tcw_pkg::NEWLINE_CODE) begin
                state_d = tcw_pkg::ST_ADVANCE;
              end else begin
                op_a    = MA_W'(y_q);
                op_b    = MB_W'(x_q);
                addr_d  = unit_sum;
                state_d = tcw_pkg::ST_PUT_WR;
              end
            end
            tcw_pkg::KIND_READ: begin
              op_a = MA_W'(cell_row_i);
              op_b = MB_W'(cell_column_i);
              if (in_range) begin
                addr_d  = unit_sum;
                state_d = tcw_pkg::ST_RD_REQ;
              end else begin
                state_d = tcw_pkg::ST_DONE;
              end
            end
            tcw_pkg::KIND_SCROLL: begin
              if (line_count_i == '0) begin
                state_d = tcw_pkg::ST_DONE;
              end else if (MA_W'(line_count_i) >= MA_W'(ROWS)) begin
                y_d     = '0;
                state_d = tcw_pkg::ST_BLANK;
              end else begin
                state_d = tcw_pkg::ST_SCR_OFF;
              end
            end
            tcw_pkg::KIND_CLEAR: begin
              y_d     = '0;
              x_d     = '0;
              state_d = tcw_pkg::ST_BLANK;
            end
            default: state_d = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_PUT_WR: begin
        we      = 1'b1;
        wdata   = {color_i, ch_q};
        state_d = tcw_pkg::ST_ADVANCE;
      end
      tcw_pkg::ST_ADVANCE: begin
        if ((ch_q == tcw_pkg::NEWLINE_CODE) || (x_q == LAST_COL)) begin
          x_d = '0;
          if (y_q == LAST_ROW) begin
            // bottom row left: scroll up one line
            n_d     = tcw_pkg::LINES_W'(1);
            state_d = tcw_pkg::ST_SCR_OFF;
          end else begin
            y_d     = y_q + RW'(1);
            state_d = tcw_pkg::ST_DONE;
          end
        end else begin
          x_d     = x_q + CW'(1);
          state_d = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_SCR_OFF: begin
        op_a    = MA_W'(n_q);
        off_d   = unit_sum;
        state_d = tcw_pkg::ST_SCR_LIM;
      end
      tcw_pkg::ST_SCR_LIM: begin
        op_a    = rows_left;
        lim_d   = unit_sum;
        y_d     = RW'(rows_left);
        addr_d  = '0;
        state_d = tcw_pkg::ST_COPY_RD;
      end
      tcw_pkg::ST_COPY_RD: begin
        state_d = tcw_pkg::ST_COPY_WR;
      end
      tcw_pkg::ST_COPY_WR: begin
        we     = 1'b1;
        wdata  = mem_rdata_i;
        addr_d = addr_next;
        if (addr_next == lim_q) begin
          state_d = tcw_pkg::ST_BLANK;
        end else begin
          state_d = tcw_pkg::ST_COPY_RD;
        end
      end
      tcw_pkg::ST_BLANK: begin
        we = 1'b1;
        if (addr_q == LAST_ADDR) begin
          addr_d  = '0;
          state_d = tcw_pkg::ST_DONE;
        end else begin
          addr_d = addr_next;
        end
      end
      tcw_pkg::ST_RD_REQ: begin
        state_d = tcw_pkg::ST_RD_DATA;
      end
      tcw_pkg::ST_RD_DATA: begin
        value_d = mem_rdata_i;
        state_d = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_DONE: begin
        state_d = tcw_pkg::ST_IDLE;
      end
      default: state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  assign busy_o          = (state_q != tcw_pkg::ST_IDLE);
  assign done_o          = (state_q == tcw_pkg::ST_DONE);
  assign mem_we_o        = we;
  assign mem_waddr_o     = addr_q;
  assign mem_wdata_o     = wdata;
  assign mem_raddr_o     = (state_q == tcw_pkg::ST_COPY_RD) ? (addr_q + off_q) : addr_q;
  assign cursor_row_o    = tcw_pkg::ROW_IN_W'(y_q);
  assign cursor_column_o = tcw_pkg::COL_IN_W'(x_q);
  assign cell_value_o    = value_q;

  `TCW_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "request taken but not busy")
  `TCW_ASSERT_SAME(a_done_busy, done_o, busy_o, "result strobe while idle")
  `TCW_ASSERT_NEXT(a_done_single, done_o, !done_o && !busy_o, "result strobe not single")
  `TCW_ASSERT_SAME(a_cursor_range, 1'b1,
                   (MA_W'(y_q) < MA_W'(ROWS)) && (MB_W'(x_q) < MB_W'(COLUMNS)),
                   "cursor off screen")
  `TCW_ASSERT_SAME(a_write_range, mem_we_o, mem_waddr_o <= LAST_ADDR, "cell write off screen")
  `TCW_ASSERT_SAME(a_value_zero, done_o && (kind_q != tcw_pkg::KIND_READ),
                   cell_value_o == '0, "cell value set for non-read")

endmodule

// File: design/text_console_writer_top.sv
// Text console writer: a put writes one cell and moves the cursor on, a newline moves it to
// the next row; a read returns one cell (zero off screen); a zero scroll does nothing; a clear or
// full scroll blanks the screen. A scroll by n < ROWS copies cells up, each read then written
// through the single screen memory; a put or newline leaving the bottom row scrolls one line.
// busy drops the cycle after the done_o strobe; results cannot be stalled. After reset the screen is
// cleared to spaces of color 2 with busy high; the color register resets to 2.
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [tcw_pkg::KIND_W-1:0]    kind_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::ROW_IN_W-1:0]  cell_row_i,
  input  logic [tcw_pkg::COL_IN_W-1:0]  cell_column_i,
  input  logic [tcw_pkg::LINES_W-1:0]   line_count_i,
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    cfg_wdata_i,
  output logic                          done_o,
  output logic [tcw_pkg::ROW_IN_W-1:0]  cursor_row_o,
  output logic [tcw_pkg::COL_IN_W-1:0]  cursor_column_o,
  output logic [tcw_pkg::CELL_W-1:0]    cell_value_o
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic [tcw_pkg::CHAR_W-1:0] color_q;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [AW-1:0]              mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= tcw_pkg::TEXT_COLOR_RESET;
    end else if (cfg_we_i) begin
      color_q <= cfg_wdata_i;
    end
  end

  tcw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .kind_i          (kind_i),
    .char_code_i     (char_code_i),
    .cell_row_i      (cell_row_i),
    .cell_column_i   (cell_column_i),
    .line_count_i    (line_count_i),
    .color_i         (color_q),
    .mem_rdata_i     (mem_rdata),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_raddr_o     (mem_raddr),
    .done_o          (done_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_column_o (cursor_column_o),
    .cell_value_o    (cell_value_o)
  );

endmodule
